### design/hai_pkg.sv
// Shared types and constants for the Hall angle interpolator.
package hai_pkg;

  // Angle and counter resolution; a full turn is 2^ANGLE_BITS.
  localparam int ANGLE_BITS = 32;
  localparam int COUNT_BITS = 16;
  localparam int SPEED_BITS = 32;
  localparam int DT_BITS    = 16;
  localparam int SECTOR_BITS = 3;
  localparam int NUM_SECTORS = 6;

  // One sector is floor(turn / 6).
  localparam longint unsigned SECTOR_WIDTH = (64'd1 << ANGLE_BITS) / NUM_SECTORS;
  localparam int TRAVEL_BITS = $clog2(SECTOR_WIDTH + 1);
  localparam int PROD_BITS   = SPEED_BITS + DT_BITS;
  localparam int SUM_BITS    = PROD_BITS + 1;

  // Stream payload widths.
  localparam int IN_DATA_BITS  = 104;
  localparam int IN_USER_BITS  = 6;
  localparam int OUT_DATA_BITS = 64;
  localparam int OUT_USER_BITS = 7;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_BAD_OBS = 2'd1,
    STATUS_BAD_ARG = 2'd2
  } status_e;

  // Driver validity flags, bit order matches the input tuser.
  typedef struct packed {
    logic timed_out;
    logic from_edge;
    logic speed_valid;
    logic angle_valid;
    logic direction_valid;
    logic state_valid;
  } obs_flags_t;

  typedef struct packed {
    logic [SECTOR_BITS-1:0] sector;
    logic [ANGLE_BITS-1:0]  edge_angle;
    logic [SPEED_BITS-1:0]  speed;
    logic [COUNT_BITS-1:0]  edge_count;
    logic [DT_BITS-1:0]     elapsed_us;
    obs_flags_t             flags;
  } obs_t;

  typedef struct packed {
    logic timeout;
    logic limited;
    logic edge_ref;
    logic speed_ok;
    logic angle_ok;
  } out_flags_t;

  typedef struct packed {
    logic [ANGLE_BITS-1:0]  est_angle;
    logic [SPEED_BITS-1:0]  held_speed;
    out_flags_t             flags;
    logic [ANGLE_BITS-1:0]  ref_angle;
    logic [TRAVEL_BITS-1:0] travel;
    logic [COUNT_BITS-1:0]  prev_count;
    logic [SECTOR_BITS-1:0] prev_sector;
    obs_flags_t             prev_flags;
    logic                   seen_any;
  } est_state_t;

  // No observation seen yet: everything clear, previous sector out of range.
  localparam est_state_t EST_STATE_RESET = '{
    est_angle:   '0,
    held_speed:  '0,
    flags:       '0,
    ref_angle:   '0,
    travel:      '0,
    prev_count:  '0,
    prev_sector: '1,
    prev_flags:  '0,
    seen_any:    1'b0
  };

  typedef struct packed {
    status_e               status;
    logic [ANGLE_BITS-1:0] angle_out;
    logic [SPEED_BITS-1:0] speed_out;
    out_flags_t            flags;
  } res_t;

endpackage

### design/hai_step.sv
// Next-state and result logic for one Hall observation.
module hai_step (
  input  hai_pkg::obs_t       obs_i,
  input  hai_pkg::est_state_t state_i,
  output hai_pkg::est_state_t state_o,
  output hai_pkg::res_t       res_o
);
  import hai_pkg::*;

  logic                   first;
  logic                   new_edge;
  logic                   is_new;
  logic                   contract_bad;
  logic                   can_integrate;
  logic                   neg;
  logic [SPEED_BITS-1:0]  mag;
  logic [PROD_BITS-1:0]   prod;
  logic [SUM_BITS-1:0]    sum;
  logic                   clamp;
  logic [TRAVEL_BITS-1:0] travel_next;
  logic                   sync;
  obs_flags_t             f;
  status_e                status;
  est_state_t             nxt;

  assign f        = obs_i.flags;
  assign first    = !state_i.seen_any;
  assign new_edge = !first && (obs_i.edge_count != state_i.prev_count);
  assign is_new   = first || new_edge || (obs_i.sector != state_i.prev_sector) ||
                    (f != state_i.prev_flags);

  assign contract_bad =
      (f.state_valid && (obs_i.sector >= SECTOR_BITS'(NUM_SECTORS))) ||
      (f.angle_valid && !f.state_valid) ||
      (f.speed_valid && (!f.state_valid || !f.angle_valid)) ||
      (f.direction_valid && !f.state_valid) ||
      (f.from_edge && (!f.state_valid || !f.direction_valid || !f.angle_valid)) ||
      (new_edge && !f.from_edge);

  assign can_integrate = state_i.flags.angle_ok && state_i.flags.speed_ok &&
                         state_i.flags.edge_ref && !state_i.flags.timeout;

  // Travel since the last edge: |speed| * dt, saturated at one sector.
  assign neg   = state_i.held_speed[SPEED_BITS-1];
  assign mag   = neg ? (~state_i.held_speed + SPEED_BITS'(1)) : state_i.held_speed;
  assign prod  = PROD_BITS'(mag) * PROD_BITS'(obs_i.elapsed_us);
  assign sum   = SUM_BITS'(prod) + SUM_BITS'(state_i.travel);
  assign clamp = sum >= SUM_BITS'(SECTOR_WIDTH);
  assign travel_next = clamp ? TRAVEL_BITS'(SECTOR_WIDTH) : sum[TRAVEL_BITS-1:0];

  assign sync = first || new_edge || !f.from_edge || !state_i.flags.angle_ok;

  always_comb begin
    nxt    = state_i;
    status = STATUS_OK;
    if (obs_i.elapsed_us == '0) begin
      status = STATUS_BAD_ARG;
    end else if (!is_new) begin
      if (can_integrate) begin
        nxt.flags.limited = clamp;
        nxt.travel        = travel_next;
        if (state_i.held_speed == '0) begin
          nxt.est_angle = state_i.ref_angle;
        end else if (neg) begin
          nxt.est_angle = state_i.ref_angle - ANGLE_BITS'(travel_next);
        end else begin
          nxt.est_angle = state_i.ref_angle + ANGLE_BITS'(travel_next);
        end
      end
    end else if (contract_bad) begin
      status = STATUS_BAD_OBS;
    end else begin
      nxt.flags.timeout = f.timed_out;
      if (!f.state_valid || !f.angle_valid) begin
        nxt.held_speed     = '0;
        nxt.flags.angle_ok = 1'b0;
        nxt.flags.speed_ok = 1'b0;
        nxt.flags.edge_ref = 1'b0;
        nxt.flags.limited  = 1'b0;
        nxt.ref_angle      = '0;
        nxt.travel         = '0;
      end else begin
        nxt.held_speed     = f.speed_valid ? obs_i.speed : '0;
        nxt.flags.speed_ok = f.speed_valid;
        if (sync) begin
          nxt.est_angle      = obs_i.edge_angle;
          nxt.flags.angle_ok = 1'b1;
          nxt.flags.edge_ref = f.from_edge;
          nxt.flags.limited  = 1'b0;
          nxt.ref_angle      = obs_i.edge_angle;
          nxt.travel         = '0;
        end
      end
      nxt.prev_count  = obs_i.edge_count;
      nxt.prev_sector = obs_i.sector;
      nxt.prev_flags  = f;
      nxt.seen_any    = 1'b1;
    end
  end

  assign state_o         = nxt;
  assign res_o.status    = status;
  assign res_o.angle_out = nxt.est_angle;
  assign res_o.speed_out = nxt.held_speed;
  assign res_o.flags     = nxt.flags;

endmodule

### design/hall_angle_interpolator.sv
// Top level of the Hall angle interpolator: stream ports, input, state and result registers.
//
// Hall angle interpolator. Each input item is one observation from a Hall
// sensor driver (sector, edge angle, signed speed, edge count, elapsed time
// and six driver flags); each item yields exactly one result item carrying a
// status, the estimated electrical angle, the held speed and five flags.
// Angles are unsigned fractions of a turn (2^32 = one turn); speed is signed
// in 2^-32 turn per microsecond. When an observation repeats the previous
// one, the angle is advanced from the last edge reference by |speed| times
// elapsed_us, clamped at one sector (floor(2^32/6)), with sector_limited set
// while clamped. A new or changed observation is checked for consistency and
// then re-syncs the angle, updates or drops the speed, or clears the outputs.
// Status 2 flags zero elapsed time, status 1 an inconsistent observation; on
// either error the held outputs are returned unchanged. Throughput is one
// item per clock while the output is not stalled: an item is registered on
// input, then one pass of the 32x16 travel multiply, clamp and wrap updates
// the estimator state and the result register, so a result passes the input
// and result registers (two register stages). The input register keeps
// accepting while a result waits; back-pressure on the output stalls the
// input only once both registers are full. Reset brings the estimator to
// the no-observation state.
module hall_angle_interpolator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // tdata: sector[2:0], edge_angle[34:3], speed[66:35], edge_count[82:67],
  //        elapsed_us[98:83], zero fill[103:99]
  input  logic [hai_pkg::IN_DATA_BITS-1:0]  s_axis_tdata,
  // tuser: state_valid, direction_valid, angle_valid, speed_valid,
  //        from_edge, timed_out (bit 0 up)
  input  logic [hai_pkg::IN_USER_BITS-1:0]  s_axis_tuser,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata: angle_out[31:0], speed_out[63:32]
  output logic [hai_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,
  // tuser: status[1:0], angle_ok, speed_ok, edge_ref, sector_limited,
  //        timeout_out (bit 2 up)
  output logic [hai_pkg::OUT_USER_BITS-1:0] m_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready
);
  import hai_pkg::*;

  obs_t       obs_in;
  obs_t       in_q;
  logic       in_valid_q;
  logic       in_valid_d;
  logic       in_take;
  logic       advance;
  logic       fire;
  est_state_t state_q;
  est_state_t state_d;
  res_t       res;
  res_t       out_q;
  logic       out_valid_q;
  logic       out_valid_d;

  // Unpack the stream payload into the observation fields.
  assign obs_in.sector     = s_axis_tdata[2:0];
  assign obs_in.edge_angle = s_axis_tdata[34:3];
  assign obs_in.speed      = s_axis_tdata[66:35];
  assign obs_in.edge_count = s_axis_tdata[82:67];
  assign obs_in.elapsed_us = s_axis_tdata[98:83];
  assign obs_in.flags      = obs_flags_t'(s_axis_tuser);

  // Advance when the result register is empty or being drained.
  assign advance       = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || fire;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  hai_step u_step (
    .obs_i   (in_q),
    .state_i (state_q),
    .state_o (state_d),
    .res_o   (res)
  );

  // Control state and estimator state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= EST_STATE_RESET;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (fire) begin
        state_q <= state_d;
      end
    end
  end

  // Payload registers: hold until the next transfer.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= obs_in;
    end
    if (fire) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.speed_out, out_q.angle_out};
  assign m_axis_tuser  = {out_q.flags, out_q.status};

endmodule

### design/hai_checker.sv
// Port-level checker for the Hall angle interpolator, bound to the top level.
module hai_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic [hai_pkg::IN_DATA_BITS-1:0]  s_axis_tdata,
  input logic [hai_pkg::IN_USER_BITS-1:0]  s_axis_tuser,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic [hai_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,
  input logic [hai_pkg::OUT_USER_BITS-1:0] m_axis_tuser,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready
);
  import hai_pkg::*;

  logic in_seen;
  assign in_seen = s_axis_tvalid && s_axis_tready && (s_axis_tdata != '0 || s_axis_tuser != '0);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // Status never takes the unused code.
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser[1:0] != 2'd3))
    else $error("unused status code");

  // Speed reads zero whenever it is not valid.
  a_speed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[3] |-> (m_axis_tdata[63:32] == '0))
    else $error("speed nonzero while not valid");

  // Clamping and edge reference only exist on a valid angle.
  a_limit_needs_angle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser[5] || m_axis_tuser[4]) |-> m_axis_tuser[2])
    else $error("limit or edge reference without valid angle");

  // Accepting an item is only possible with the input side ready.
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_seen |-> s_axis_tready)
    else $error("item accepted while not ready");

endmodule

bind hall_angle_interpolator hai_checker u_hai_checker (.*);
